// ----- rtl/core/tcspc_sync_delay_tagger_assert.svh -----
// ----------------------------------------------------------------------------
// tcspc sync delay tagger assertion macros
// clocked implication macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef TCSPC_SYNC_DELAY_TAGGER_ASSERT_SVH
`define TCSPC_SYNC_DELAY_TAGGER_ASSERT_SVH

// same-cycle implication
`define TSDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsdt assertion failed");

// next-cycle implication
`define TSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsdt assertion failed");

`endif

// ----- rtl/core/tsdt_pkg.sv -----
// ----------------------------------------------------------------------------
// tsdt package
// widths, payload types, register indexes and control/status bundles
// ----------------------------------------------------------------------------
package tsdt_pkg;

	localparam int CHAN_W     = 8;
	localparam int TIME_W     = 63;
	localparam int PER_W      = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	typedef logic signed [CHAN_W-1:0] chan_t;
	typedef logic [TIME_W-1:0]        time_t;
	typedef logic [PER_W-1:0]         period_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	localparam cfg_idx_t REG_SYNC_CHANNEL = 2'd0;
	localparam cfg_idx_t REG_SYNC_PERIOD  = 2'd1;
	localparam cfg_idx_t REG_DELAY_MODE   = 2'd2;

	localparam chan_t   SYNC_ID_RST = '0;
	localparam period_t PERIOD_RST  = 40'd12500;
	localparam time_t   TIME_MAX    = '1;

	typedef struct packed {
		logic accept;
		logic prep;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic is_sync;
		logic count_zero;
		logic div_busy;
		logic last;
	} status_t;

endpackage

// ----- rtl/core/tsdt_if.sv -----
// ----------------------------------------------------------------------------
// tsdt channel interfaces
// event input, record output and register write channels
// ----------------------------------------------------------------------------
interface tsdt_event_if;
	import tsdt_pkg::*;

	logic  valid;
	logic  ready;
	chan_t event_channel;
	time_t event_time;

	modport source (output valid, output event_channel, output event_time, input ready);
	modport sink (input valid, input event_channel, input event_time, output ready);
endinterface

interface tsdt_record_if;
	import tsdt_pkg::*;

	logic  valid;
	logic  ready;
	chan_t out_channel;
	time_t sync_number;
	time_t count_delay;
	logic  dropped;
	logic  last_of_run;

	modport source (
		output valid, output out_channel, output sync_number, output count_delay,
		output dropped, output last_of_run, input ready
	);
	modport sink (
		input valid, input out_channel, input sync_number, input count_delay,
		input dropped, input last_of_run, output ready
	);
endinterface

interface tsdt_cfg_if;
	import tsdt_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tsdt_div.sv -----
// ----------------------------------------------------------------------------
// tsdt divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tsdt_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tsdt_pkg::time_t   dividend,
	input  tsdt_pkg::period_t divisor,
	output logic             busy,
	output tsdt_pkg::time_t   quotient
);
	import tsdt_pkg::*;

	localparam int CNT_W = $clog2(TIME_W + 1);

	logic [CNT_W-1:0] cnt_q;
	time_t            dq_q;
	period_t          rem_q;
	period_t          div_q;
	logic [PER_W:0]   r_sh;
	logic [PER_W+1:0] r_sub;
	logic             ge;

	assign r_sh  = {rem_q, dq_q[TIME_W-1]};
	assign r_sub = {1'b0, r_sh} - (PER_W+2)'(div_q);
	assign ge    = !r_sub[PER_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(TIME_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			dq_q  <= {dq_q[TIME_W-2:0], ge};
			rem_q <= ge ? r_sub[PER_W-1:0] : r_sh[PER_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = dq_q;

endmodule

// ----- rtl/core/tsdt_dp.sv -----
// ----------------------------------------------------------------------------
// tsdt datapath
// registers, pending event store, sync number division and delay arithmetic
// ----------------------------------------------------------------------------
module tsdt_dp #(
	parameter int FIFO_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsdt_pkg::cmd_t      cmd,
	output tsdt_pkg::status_t   st,
	input  logic                cfg_we,
	input  tsdt_pkg::cfg_idx_t  cfg_index,
	input  tsdt_pkg::cfg_data_t cfg_data,
	input  tsdt_pkg::chan_t     in_channel,
	input  tsdt_pkg::time_t     in_time,
	output tsdt_pkg::chan_t     out_channel,
	output tsdt_pkg::time_t     sync_number,
	output tsdt_pkg::time_t     count_delay,
	output logic                dropped,
	output logic                last_of_run
);
	import tsdt_pkg::*;

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	typedef enum logic [1:0] {
		DK_SUB_CLAMP,
		DK_ABS,
		DK_ADD_SAT
	} dkind_t;

	chan_t      sync_id_q;
	period_t    period_q;
	logic       mode_q;

	chan_t      mem_chan [FIFO_DEPTH];
	time_t      mem_time [FIFO_DEPTH];
	chan_t      rd_chan_q;
	time_t      rd_time_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] k_q;
	logic       ovf_q;
	logic       seen_q;
	time_t      first_q;
	time_t      sync_q;
	time_t      base_q;
	dkind_t     kind_q;

	logic       is_sync;
	logic       full;
	logic       last;
	period_t    period_eff;
	logic [TIME_W:0] diff_full;
	time_t      diff;
	logic [TIME_W:0] ref_full;
	logic       div_busy;
	time_t      quot;
	time_t      num;
	logic [TIME_W:0] a_full;
	logic [TIME_W:0] b_full;
	logic [TIME_W:0] c_full;
	time_t      delay;

	chan_t      out_chan_q;
	time_t      out_num_q;
	time_t      out_delay_q;
	logic       out_drop_q;
	logic       out_last_q;

	assign is_sync = (in_channel == sync_id_q);
	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign last    = (({1'b0, k_q} + (CNT_W+1)'(1)) == {1'b0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_id_q <= SYNC_ID_RST;
			period_q  <= PERIOD_RST;
			mode_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_CHANNEL: sync_id_q <= chan_t'(cfg_data[CHAN_W-1:0]);
				REG_SYNC_PERIOD:  period_q  <= cfg_data[PER_W-1:0];
				REG_DELAY_MODE:   mode_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
			first_q <= '0;
		end else if (cmd.accept) begin
			if (!is_sync) begin
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (!seen_q) begin
				seen_q  <= 1'b1;
				first_q <= in_time;
			end
		end else if (cmd.load && last) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	// pending event store
	always_ff @(posedge clk) begin
		if (cmd.accept && !is_sync && !full) begin
			mem_chan[count_q[IDX_W-1:0]] <= in_channel;
			mem_time[count_q[IDX_W-1:0]] <= in_time;
		end
		rd_chan_q <= mem_chan[k_q[IDX_W-1:0]];
		rd_time_q <= mem_time[k_q[IDX_W-1:0]];
	end

	assign period_eff = (period_q == '0) ? PER_W'(1) : period_q;
	assign diff_full  = {1'b0, sync_q} - {1'b0, first_q};
	assign diff       = diff_full[TIME_W] ? '0 : diff_full[TIME_W-1:0];
	assign ref_full   = {1'b0, sync_q} - (TIME_W+1)'(period_eff);

	always_ff @(posedge clk) begin
		if (cmd.accept && is_sync) begin
			sync_q <= in_time;
		end
		if (cmd.prep) begin
			k_q <= '0;
			if (!mode_q) begin
				kind_q <= DK_SUB_CLAMP;
				base_q <= sync_q;
			end else if (!ref_full[TIME_W]) begin
				kind_q <= DK_ABS;
				base_q <= ref_full[TIME_W-1:0];
			end else begin
				// reference below zero
				kind_q <= DK_ADD_SAT;
				base_q <= TIME_W'(period_eff) - sync_q;
			end
		end else if (cmd.load) begin
			k_q <= k_q + CNT_W'(1);
		end
	end

	tsdt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.prep),
		.dividend (diff),
		.divisor  (period_eff),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign num    = (quot == TIME_MAX) ? TIME_MAX : quot + TIME_W'(1);
	assign a_full = {1'b0, rd_time_q} - {1'b0, base_q};
	assign b_full = {1'b0, base_q} - {1'b0, rd_time_q};
	assign c_full = {1'b0, rd_time_q} + {1'b0, base_q};

	always_comb begin
		unique case (kind_q)
			DK_SUB_CLAMP: delay = b_full[TIME_W] ? '0 : b_full[TIME_W-1:0];
			DK_ABS:       delay = a_full[TIME_W] ? b_full[TIME_W-1:0] : a_full[TIME_W-1:0];
			DK_ADD_SAT:   delay = c_full[TIME_W] ? TIME_MAX : c_full[TIME_W-1:0];
			default:      delay = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_chan_q  <= rd_chan_q;
			out_num_q   <= num;
			out_delay_q <= delay;
			out_drop_q  <= ovf_q;
			out_last_q  <= last;
		end
	end

	assign st.is_sync    = is_sync;
	assign st.count_zero = (count_q == '0);
	assign st.div_busy   = div_busy;
	assign st.last       = last;

	assign out_channel = out_chan_q;
	assign sync_number = out_num_q;
	assign count_delay = out_delay_q;
	assign dropped     = out_drop_q;
	assign last_of_run = out_last_q;

endmodule

// ----- rtl/core/tsdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsdt controller
// sequences event intake, division and record drain; owns output valid
// ----------------------------------------------------------------------------
module tsdt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tsdt_pkg::status_t st,
	output tsdt_pkg::cmd_t    cmd
);
	import tsdt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_READ,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready   = (state_q == S_IDLE);
	assign slot_free  = !out_valid_q || out_ready;
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	assign cmd.prep   = (state_q == S_PREP);
	assign cmd.load   = (state_q == S_LOAD) && slot_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept && st.is_sync && !st.count_zero) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_DIV;
				S_DIV: begin
					if (!st.div_busy) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if (cmd.load) begin
						state_q <= st.last ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/tcspc_sync_delay_tagger.sv -----
// ----------------------------------------------------------------------------
// tcspc sync delay tagger
// reverse start-stop tagging of detector events against sync pulses
// ----------------------------------------------------------------------------
// channel   dir   handshake       payload
// events    in    valid/ready     event_channel, event_time
// records   out   valid/ready     out_channel, sync_number, count_delay,
//                                 dropped, last_of_run
// cfg       in    valid/ready     index, data (ready always high)
//
// a detector event is stored while idle; a sync with n pending events runs
// the 63-step sync number divider, then reads each pending entry through
// the read and load states
// asynchronous active-low reset clears control state and configuration registers
// records wait in an output register; a stalled output holds the drain
// ----------------------------------------------------------------------------
module tcspc_sync_delay_tagger #(
	parameter int FIFO_DEPTH = 32
) (
	input logic           clk,
	input logic           arst_n,
	tsdt_event_if.sink    events,
	tsdt_record_if.source records,
	tsdt_cfg_if.sink      cfg
);
	import tsdt_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg.ready = 1'b1;

	tsdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (events.valid),
		.in_ready  (events.ready),
		.out_valid (records.valid),
		.out_ready (records.ready),
		.st        (st),
		.cmd       (cmd)
	);

	tsdt_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.in_channel  (events.event_channel),
		.in_time     (events.event_time),
		.out_channel (records.out_channel),
		.sync_number (records.sync_number),
		.count_delay (records.count_delay),
		.dropped     (records.dropped),
		.last_of_run (records.last_of_run)
	);

endmodule

// ----- rtl/core/tsdt_checker.sv -----
// ----------------------------------------------------------------------------
// tsdt checker
// port-level checks of record output behavior, bound to the top level
// ----------------------------------------------------------------------------
`include "tcspc_sync_delay_tagger_assert.svh"

module tsdt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input tsdt_pkg::chan_t out_channel,
	input tsdt_pkg::time_t sync_number,
	input tsdt_pkg::time_t count_delay,
	input logic            dropped,
	input logic            last_of_run
);
	import tsdt_pkg::*;

	// stalled record stays valid and keeps its channel, delay, sync number and last flag
	`TSDT_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(count_delay) && $stable(sync_number) && $stable(last_of_run))

	// no intake while a run is being drained
	`TSDT_ASSERT_SAME(a_busy_drain, clk, arst_n, out_valid && !last_of_run, !in_ready)

	// sync number and drop flag are shared by all records of a run
	`TSDT_ASSERT_NEXT(a_run_same, clk, arst_n, out_valid && out_ready && !last_of_run, !out_valid || (sync_number == $past(sync_number) && dropped == $past(dropped)))

	// sync numbers start at one
	`TSDT_ASSERT_SAME(a_num_pos, clk, arst_n, out_valid, sync_number != '0)

endmodule

bind tcspc_sync_delay_tagger tsdt_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (events.ready),
	.out_valid   (records.valid),
	.out_ready   (records.ready),
	.out_channel (records.out_channel),
	.sync_number (records.sync_number),
	.count_delay (records.count_delay),
	.dropped     (records.dropped),
	.last_of_run (records.last_of_run)
);
